/* src/lcpp_pkg.sv */
// shared types and constants for the led color pixel pipeline
package lcpp_pkg;

    // component and field widths
    localparam int COMP_W  = 8;
    localparam int PROD_W  = 2 * COMP_W;
    localparam int CFG_A_W = 2;

    // hue region geometry of the six-region scheme
    localparam int REGION_WIDTH = 43;
    localparam int NUM_REGIONS  = 6;
    localparam int FRAC_SCALE   = 6;

    // reset level of the global brightness
    localparam logic [COMP_W-1:0] BRIGHT_RESET = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_GAMMA  = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_ORDER  = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_BRIGHT = 2'd2;

    // channel order codes
    localparam logic ORDER_GRB = 1'b0;
    localparam logic ORDER_RGB = 1'b1;

    // pixel color mode
    typedef enum logic {
        MODE_RGB = 1'b0,
        MODE_HSV = 1'b1
    } mode_t;

    // hue region, named by the hue span it covers
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    // after decode: region found, rgb path finished, first hsv product
    typedef struct packed {
        mode_t              mode;
        logic               grey;
        sector_t            sector;
        logic [COMP_W-1:0]  sat;
        logic [COMP_W-1:0]  val;
        logic [COMP_W-1:0]  frac;
        logic [COMP_W-1:0]  red0;
        logic [COMP_W-1:0]  green0;
        logic [COMP_W-1:0]  blue0;
        logic [PROD_W-1:0]  lo_prod;
    } dec_t;

    // after the saturation products
    typedef struct packed {
        mode_t              mode;
        logic               grey;
        sector_t            sector;
        logic [COMP_W-1:0]  val;
        logic [COMP_W-1:0]  red0;
        logic [COMP_W-1:0]  green0;
        logic [COMP_W-1:0]  blue0;
        logic [COMP_W-1:0]  lo;
        logic [COMP_W-1:0]  sat_fall;
        logic [COMP_W-1:0]  sat_rise;
    } sat_t;

    // after the value products: every candidate channel level known
    typedef struct packed {
        mode_t              mode;
        logic               grey;
        sector_t            sector;
        logic [COMP_W-1:0]  val;
        logic [COMP_W-1:0]  red0;
        logic [COMP_W-1:0]  green0;
        logic [COMP_W-1:0]  blue0;
        logic [COMP_W-1:0]  lo;
        logic [COMP_W-1:0]  fall;
        logic [COMP_W-1:0]  rise;
    } lvl_t;

    // three output bytes in send order
    typedef struct packed {
        logic [COMP_W-1:0]  third;
        logic [COMP_W-1:0]  second;
        logic [COMP_W-1:0]  first;
    } pix_t;

endpackage

/* src/lcpp_decode.sv */
// stage one: hue region search, gamma squares and the low hsv level product
module lcpp_decode (
    input  logic                          aclk,
    input  logic                          en,
    input  logic                          gamma_enable,
    input  lcpp_pkg::mode_t               color_mode,
    input  logic [lcpp_pkg::COMP_W-1:0]   comp_a,
    input  logic [lcpp_pkg::COMP_W-1:0]   comp_b,
    input  logic [lcpp_pkg::COMP_W-1:0]   comp_c,
    output lcpp_pkg::dec_t                dec_reg
);

    lcpp_pkg::dec_t                 dec_next;
    lcpp_pkg::sector_t              sector;
    logic [lcpp_pkg::COMP_W-1:0]    base;
    logic [lcpp_pkg::COMP_W-1:0]    rem;
    logic [lcpp_pkg::COMP_W-1:0]    gam_a;
    logic [lcpp_pkg::COMP_W-1:0]    gam_b;
    logic [lcpp_pkg::COMP_W-1:0]    gam_c;

    // square-law gamma ((x+1)^2-1)>>8
    function automatic logic [lcpp_pkg::COMP_W-1:0] square_gamma(
        input logic [lcpp_pkg::COMP_W-1:0] x
    );
        logic [lcpp_pkg::COMP_W:0]     xp1;
        logic [2*lcpp_pkg::COMP_W+1:0] sq;
        logic [2*lcpp_pkg::COMP_W+1:0] dec;
        xp1 = {1'b0, x} + 1'b1;
        sq  = {{(lcpp_pkg::COMP_W+1){1'b0}}, xp1} * {{(lcpp_pkg::COMP_W+1){1'b0}}, xp1};
        dec = sq - 1'b1;
        return dec[2*lcpp_pkg::COMP_W-1:lcpp_pkg::COMP_W];
    endfunction

    // region = hue / 43 by threshold compares, and the region start
    always_comb begin
        sector = lcpp_pkg::SEC_R_TO_Y;
        base   = '0;
        for (int k = 1; k < lcpp_pkg::NUM_REGIONS; k++) begin
            if (comp_a >= 8'(k * lcpp_pkg::REGION_WIDTH)) begin
                sector = lcpp_pkg::sector_t'(3'(k));
                base   = 8'(k * lcpp_pkg::REGION_WIDTH);
            end
        end
        rem = comp_a - base;
    end

    assign gam_a = square_gamma(comp_a);
    assign gam_b = square_gamma(comp_b);
    assign gam_c = square_gamma(comp_c);

    // next stage contents
    always_comb begin
        dec_next.mode    = color_mode;
        dec_next.grey    = (comp_b == '0);
        dec_next.sector  = sector;
        dec_next.sat     = comp_b;
        dec_next.val     = comp_c;
        dec_next.frac    = 8'(rem * lcpp_pkg::FRAC_SCALE);
        dec_next.red0    = gamma_enable ? gam_a : comp_a;
        dec_next.green0  = gamma_enable ? gam_b : comp_b;
        dec_next.blue0   = gamma_enable ? gam_c : comp_c;
        dec_next.lo_prod = {{lcpp_pkg::COMP_W{1'b0}}, comp_c}
                         * {{lcpp_pkg::COMP_W{1'b0}}, ~comp_b};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dec_reg <= dec_next;
        end
    end

endmodule

/* src/lcpp_hsv.sv */
// stages two and three: saturation products, then value products of the hsv ramps
module lcpp_hsv (
    input  logic            aclk,
    input  logic            en_sat,
    input  logic            en_lvl,
    input  lcpp_pkg::dec_t  dec_in,
    output lcpp_pkg::lvl_t  lvl_reg
);

    lcpp_pkg::sat_t                 sat_reg;
    lcpp_pkg::sat_t                 sat_next;
    lcpp_pkg::lvl_t                 lvl_next;
    logic [lcpp_pkg::PROD_W-1:0]    p_fall;
    logic [lcpp_pkg::PROD_W-1:0]    p_rise;
    logic [lcpp_pkg::PROD_W-1:0]    v_fall;
    logic [lcpp_pkg::PROD_W-1:0]    v_rise;

    // s*frac and s*(255-frac)
    always_comb begin
        p_fall = {{lcpp_pkg::COMP_W{1'b0}}, dec_in.sat}
               * {{lcpp_pkg::COMP_W{1'b0}}, dec_in.frac};
        p_rise = {{lcpp_pkg::COMP_W{1'b0}}, dec_in.sat}
               * {{lcpp_pkg::COMP_W{1'b0}}, ~dec_in.frac};
        sat_next.mode     = dec_in.mode;
        sat_next.grey     = dec_in.grey;
        sat_next.sector   = dec_in.sector;
        sat_next.val      = dec_in.val;
        sat_next.red0     = dec_in.red0;
        sat_next.green0   = dec_in.green0;
        sat_next.blue0    = dec_in.blue0;
        sat_next.lo       = dec_in.lo_prod[lcpp_pkg::PROD_W-1:lcpp_pkg::COMP_W];
        sat_next.sat_fall = p_fall[lcpp_pkg::PROD_W-1:lcpp_pkg::COMP_W];
        sat_next.sat_rise = p_rise[lcpp_pkg::PROD_W-1:lcpp_pkg::COMP_W];
    end

    always_ff @(posedge aclk) begin
        if (en_sat) begin
            sat_reg <= sat_next;
        end
    end

    // v*(255-x)>>8 for the falling and rising ramps
    always_comb begin
        v_fall = {{lcpp_pkg::COMP_W{1'b0}}, sat_reg.val}
               * {{lcpp_pkg::COMP_W{1'b0}}, ~sat_reg.sat_fall};
        v_rise = {{lcpp_pkg::COMP_W{1'b0}}, sat_reg.val}
               * {{lcpp_pkg::COMP_W{1'b0}}, ~sat_reg.sat_rise};
        lvl_next.mode   = sat_reg.mode;
        lvl_next.grey   = sat_reg.grey;
        lvl_next.sector = sat_reg.sector;
        lvl_next.val    = sat_reg.val;
        lvl_next.red0   = sat_reg.red0;
        lvl_next.green0 = sat_reg.green0;
        lvl_next.blue0  = sat_reg.blue0;
        lvl_next.lo     = sat_reg.lo;
        lvl_next.fall   = v_fall[lcpp_pkg::PROD_W-1:lcpp_pkg::COMP_W];
        lvl_next.rise   = v_rise[lcpp_pkg::PROD_W-1:lcpp_pkg::COMP_W];
    end

    always_ff @(posedge aclk) begin
        if (en_lvl) begin
            lvl_reg <= lvl_next;
        end
    end

endmodule

/* src/lcpp_scale.sv */
// stages four and five: channel select, reorder, brightness product and divide by 255
module lcpp_scale (
    input  logic                          aclk,
    input  logic                          en_mul,
    input  logic                          en_out,
    input  logic                          order_select,
    input  logic [lcpp_pkg::COMP_W-1:0]   brightness,
    input  lcpp_pkg::lvl_t                lvl_in,
    output lcpp_pkg::pix_t                pix_reg
);

    logic [lcpp_pkg::COMP_W-1:0]  red;
    logic [lcpp_pkg::COMP_W-1:0]  green;
    logic [lcpp_pkg::COMP_W-1:0]  blue;
    logic [lcpp_pkg::COMP_W-1:0]  first;
    logic [lcpp_pkg::COMP_W-1:0]  second;
    logic [lcpp_pkg::PROD_W-1:0]  prod_reg [3];
    logic [lcpp_pkg::PROD_W-1:0]  prod_next [3];
    lcpp_pkg::pix_t               pix_next;

    // exact x/255 for x up to 255*255
    function automatic logic [lcpp_pkg::COMP_W-1:0] div255(
        input logic [lcpp_pkg::PROD_W-1:0] x
    );
        logic [lcpp_pkg::PROD_W:0] sum;
        sum = {1'b0, x} + 1'b1
            + {{(lcpp_pkg::COMP_W+1){1'b0}}, x[lcpp_pkg::PROD_W-1:lcpp_pkg::COMP_W]};
        return sum[lcpp_pkg::PROD_W-1:lcpp_pkg::COMP_W];
    endfunction

    // pick channel levels from the rgb path or the hsv region
    always_comb begin
        red   = lvl_in.val;
        green = lvl_in.val;
        blue  = lvl_in.val;
        if (lvl_in.mode == lcpp_pkg::MODE_RGB) begin
            red   = lvl_in.red0;
            green = lvl_in.green0;
            blue  = lvl_in.blue0;
        end else if (!lvl_in.grey) begin
            unique case (lvl_in.sector)
                lcpp_pkg::SEC_R_TO_Y: begin
                    red = lvl_in.val;  green = lvl_in.rise; blue = lvl_in.lo;
                end
                lcpp_pkg::SEC_Y_TO_G: begin
                    red = lvl_in.fall; green = lvl_in.val;  blue = lvl_in.lo;
                end
                lcpp_pkg::SEC_G_TO_C: begin
                    red = lvl_in.lo;   green = lvl_in.val;  blue = lvl_in.rise;
                end
                lcpp_pkg::SEC_C_TO_B: begin
                    red = lvl_in.lo;   green = lvl_in.fall; blue = lvl_in.val;
                end
                lcpp_pkg::SEC_B_TO_M: begin
                    red = lvl_in.rise; green = lvl_in.lo;   blue = lvl_in.val;
                end
                default: begin
                    red = lvl_in.val;  green = lvl_in.lo;   blue = lvl_in.fall;
                end
            endcase
        end
    end

    // send order, then brightness products
    always_comb begin
        first  = (order_select == lcpp_pkg::ORDER_GRB) ? green : red;
        second = (order_select == lcpp_pkg::ORDER_GRB) ? red : green;
        prod_next[0] = {{lcpp_pkg::COMP_W{1'b0}}, first}
                     * {{lcpp_pkg::COMP_W{1'b0}}, brightness};
        prod_next[1] = {{lcpp_pkg::COMP_W{1'b0}}, second}
                     * {{lcpp_pkg::COMP_W{1'b0}}, brightness};
        prod_next[2] = {{lcpp_pkg::COMP_W{1'b0}}, blue}
                     * {{lcpp_pkg::COMP_W{1'b0}}, brightness};
    end

    always_ff @(posedge aclk) begin
        if (en_mul) begin
            prod_reg <= prod_next;
        end
    end

    // divide by 255 into the output register
    always_comb begin
        pix_next.first  = div255(prod_reg[0]);
        pix_next.second = div255(prod_reg[1]);
        pix_next.third  = div255(prod_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            pix_reg <= pix_next;
        end
    end

endmodule

/* src/led_color_pixel_pipeline_core.sv */
// top level: config registers, stage valid chain and the pixel datapath
// an accepted request passes the decode, saturation, level, product and output registers in turn
// throughput: one pixel per cycle while m_tready holds; empty stages close up under output stalls
// each of the five register stages holds at most one multiplier row per channel
// reset (aresetn low, synchronous) clears all stage valids, gamma off,
// grb order and full brightness; no clearing pass is needed
module led_color_pixel_pipeline_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [lcpp_pkg::CFG_A_W-1:0]    cfg_addr,
    input  logic [lcpp_pkg::COMP_W-1:0]     cfg_wdata,
    // pixel request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,  // comp_a, comp_b, comp_c
    input  logic                            s_tuser,  // color_mode
    // byte result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata   // byte_first, byte_second, byte_third
);

    localparam int NUM_STAGES = 5;

    logic                           gamma_enable_reg;
    logic                           order_select_reg;
    logic [lcpp_pkg::COMP_W-1:0]    brightness_reg;
    logic [NUM_STAGES-1:0]          valid_reg;
    logic [NUM_STAGES-1:0]          valid_next;
    logic [NUM_STAGES-1:0]          en;
    lcpp_pkg::dec_t                 dec_q;
    lcpp_pkg::lvl_t                 lvl_q;
    lcpp_pkg::pix_t                 pix_q;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_enable_reg <= 1'b0;
            order_select_reg <= lcpp_pkg::ORDER_GRB;
            brightness_reg   <= lcpp_pkg::BRIGHT_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == lcpp_pkg::CFG_GAMMA) begin
                gamma_enable_reg <= cfg_wdata[0];
            end
            if (cfg_addr == lcpp_pkg::CFG_ORDER) begin
                order_select_reg <= cfg_wdata[0];
            end
            if (cfg_addr == lcpp_pkg::CFG_BRIGHT) begin
                brightness_reg <= cfg_wdata;
            end
        end
    end

    // a stage loads when it is empty or its successor moves on
    always_comb begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next = valid_reg;
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                valid_next[k] = (k == 0) ? s_tvalid : valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = pix_q;

    // datapath stages
    lcpp_decode u_decode (
        .aclk         (aclk),
        .en           (en[0]),
        .gamma_enable (gamma_enable_reg),
        .color_mode   (lcpp_pkg::mode_t'(s_tuser)),
        .comp_a       (s_tdata[7:0]),
        .comp_b       (s_tdata[15:8]),
        .comp_c       (s_tdata[23:16]),
        .dec_reg      (dec_q)
    );

    lcpp_hsv u_hsv (
        .aclk    (aclk),
        .en_sat  (en[1]),
        .en_lvl  (en[2]),
        .dec_in  (dec_q),
        .lvl_reg (lvl_q)
    );

    lcpp_scale u_scale (
        .aclk         (aclk),
        .en_mul       (en[3]),
        .en_out       (en[4]),
        .order_select (order_select_reg),
        .brightness   (brightness_reg),
        .lvl_in       (lvl_q),
        .pix_reg      (pix_q)
    );

    // a ready sink never stalls the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output side can drain");

    // an accepted request reaches the output when the output side does not stall
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("request lost in the pipeline");

    // reset leaves no stage holding a result
    assert property (@(posedge aclk)
        $past(!aresetn) |-> (valid_reg == '0))
        else $error("stage valid survived reset");

endmodule
